>>> rtl/sliding_window_median_defines.svh
// ----------------------------------------------------------------------------
// Sliding window median - assertion macros
// Shared property wrappers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Same-cycle implication
`define SWM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types of the sliding window median block.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    // Default window capacity
    localparam int WINDOW_MAX_DEF = 16;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int WSIZE_W  = 5;

    // Broadcast control for the sorted cell chain
    typedef struct packed {
        logic clear;   // drop the whole window before this insert
        logic evict;   // remove the oldest sample
        logic insert;  // insert new_val in sorted position
    } swm_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/swm_in_if.sv
// ----------------------------------------------------------------------------
// swm_in_if
// Sample request channel: valid/ready with sample and restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_in_if;
    import swm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       new_sequence;

    modport source (output valid, output sample, output new_sequence, input ready);
    modport sink   (input valid, input sample, input new_sequence, output ready);
endinterface

`default_nettype wire

>>> rtl/swm_out_if.sv
// ----------------------------------------------------------------------------
// swm_out_if
// Result request channel: valid/ready with twice-median and its valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_out_if;
    import swm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [MEDIAN_W-1:0] median_twice;
    logic                       median_valid;

    modport source (output valid, output median_twice, output median_valid, input ready);
    modport sink   (input valid, input median_twice, input median_valid, output ready);
endinterface

`default_nettype wire

>>> rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: value, age tag and valid bit. Removes the
// oldest entry by pulling from the right neighbor, then inserts by pushing
// toward the right, all in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell #(
    parameter int AGE_W = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swm_pkg::swm_ctrl_t                 ctrl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] new_val,
    input  logic [AGE_W-1:0]                   last_age,
    // from left neighbor (after removal)
    input  logic                               rm_in,
    input  logic                               take_in,
    input  logic                               left_vld,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] left_val,
    input  logic [AGE_W-1:0]                   left_age,
    // from right neighbor (current contents)
    input  logic                               right_vld,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] right_val,
    input  logic [AGE_W-1:0]                   right_age,
    // to right neighbor
    output logic                               rm_out,
    output logic                               take_out,
    output logic                               post_vld,
    output logic signed [swm_pkg::SAMPLE_W-1:0] post_val,
    output logic [AGE_W-1:0]                   post_age,
    // to left neighbor and median taps
    output logic                               cur_vld,
    output logic signed [swm_pkg::SAMPLE_W-1:0] cur_val,
    output logic [AGE_W-1:0]                   cur_age
);
    import swm_pkg::*;

    logic                       vld_reg;
    logic                       vld_next;
    logic signed [SAMPLE_W-1:0] val_reg;
    logic signed [SAMPLE_W-1:0] val_next;
    logic [AGE_W-1:0]           age_reg;
    logic [AGE_W-1:0]           age_next;
    logic                       oldest;
    logic                       rm_here;
    logic                       take;

    // Contents as seen this cycle (restart empties the window)
    assign cur_vld = vld_reg & ~ctrl.clear;
    assign cur_val = val_reg;
    assign cur_age = age_reg;

    // Removal: this slot or one to its left leaves, so pull from the right
    assign oldest  = ctrl.evict & cur_vld & (age_reg == last_age);
    assign rm_here = rm_in | oldest;
    assign rm_out  = rm_here;

    assign post_vld = rm_here ? right_vld : cur_vld;
    assign post_val = rm_here ? right_val : val_reg;
    assign post_age = rm_here ? right_age : age_reg;

    // New sample belongs at or left of this slot
    assign take     = ~post_vld | (post_val > new_val);
    assign take_out = take;

    // Next slot contents
    always_comb
    begin
        vld_next = vld_reg;
        val_next = val_reg;
        age_next = age_reg;
        if (ctrl.insert)
        begin
            if (take_in)
            begin
                vld_next = left_vld;
                val_next = left_val;
                age_next = left_age + AGE_W'(1);
            end
            else if (take)
            begin
                vld_next = 1'b1;
                val_next = new_val;
                age_next = '0;
            end
            else
            begin
                vld_next = post_vld;
                val_next = post_val;
                age_next = post_age + AGE_W'(1);
            end
        end
        else if (ctrl.evict)
        begin
            vld_next = post_vld;
            val_next = post_val;
            age_next = post_age;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

endmodule

`default_nettype wire

>>> rtl/swm_chain.sv
// ----------------------------------------------------------------------------
// swm_chain
// Row of sorted window cells, lowest value at slot 0. Exposes every held
// value as a tap for the median select.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_chain #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
    parameter int AGE_W      = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swm_pkg::swm_ctrl_t                 ctrl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] new_val,
    input  logic [AGE_W-1:0]                   last_age,
    output logic signed [swm_pkg::SAMPLE_W-1:0] tap_val [WINDOW_MAX]
);
    import swm_pkg::*;

    logic                       rm_o     [WINDOW_MAX];
    logic                       take_o   [WINDOW_MAX];
    logic                       post_vld [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] post_val [WINDOW_MAX];
    logic [AGE_W-1:0]           post_age [WINDOW_MAX];
    logic                       cur_vld  [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] cur_val  [WINDOW_MAX];
    logic [AGE_W-1:0]           cur_age  [WINDOW_MAX];

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic                       rm_l;
        logic                       take_l;
        logic                       vld_l;
        logic signed [SAMPLE_W-1:0] val_l;
        logic [AGE_W-1:0]           age_l;
        logic                       vld_r;
        logic signed [SAMPLE_W-1:0] val_r;
        logic [AGE_W-1:0]           age_r;

        // Left end of the row
        if (i == 0)
        begin : g_head
            assign rm_l   = 1'b0;
            assign take_l = 1'b0;
            assign vld_l  = 1'b0;
            assign val_l  = '0;
            assign age_l  = '0;
        end
        else
        begin : g_left
            assign rm_l   = rm_o[i-1];
            assign take_l = take_o[i-1];
            assign vld_l  = post_vld[i-1];
            assign val_l  = post_val[i-1];
            assign age_l  = post_age[i-1];
        end

        // Right end of the row
        if (i == WINDOW_MAX - 1)
        begin : g_tail
            assign vld_r = 1'b0;
            assign val_r = '0;
            assign age_r = '0;
        end
        else
        begin : g_right
            assign vld_r = cur_vld[i+1];
            assign val_r = cur_val[i+1];
            assign age_r = cur_age[i+1];
        end

        swm_cell #(
            .AGE_W (AGE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_val   (new_val),
            .last_age  (last_age),
            .rm_in     (rm_l),
            .take_in   (take_l),
            .left_vld  (vld_l),
            .left_val  (val_l),
            .left_age  (age_l),
            .right_vld (vld_r),
            .right_val (val_r),
            .right_age (age_r),
            .rm_out    (rm_o[i]),
            .take_out  (take_o[i]),
            .post_vld  (post_vld[i]),
            .post_val  (post_val[i]),
            .post_age  (post_age[i]),
            .cur_vld   (cur_vld[i]),
            .cur_val   (cur_val[i]),
            .cur_age   (cur_age[i])
        );

        assign tap_val[i] = cur_val[i];
    end

endmodule

`default_nettype wire

>>> rtl/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over the last window_size samples of a signed stream.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one sample per request, with new_sequence set on the
//   first sample of a sequence (the window is emptied before it enters).
//   median_ch returns one result per sample: median_twice is the sum of the
//   two middle values of the sorted window (twice the median), and
//   median_valid is set once the window holds window_size samples; before
//   that median_twice is zero.
//   cfg_wr_en/cfg_wr_data write window_size (0 acts as 1, values above
//   WINDOW_MAX act as WINDOW_MAX); write it only while the block is idle.
// Timing:
//   One sample per cycle in steady state; a result passes through the pending
//   flag, then the output register. The sorted cell chain drops one sample
//   per cycle while a sample waits, so after window_size is lowered the next
//   non-restart sample waits (sample_ch.ready low) until the excess is gone.
// Reset and stall:
//   Reset empties the window and sets window_size to 1. A stalled median_ch
//   holds its result; one more result waits inside, then sample_ch.ready
//   drops until median_ch drains.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [swm_pkg::WSIZE_W-1:0]      cfg_wr_data,
    swm_in_if.sink                           sample_ch,
    swm_out_if.source                        median_ch
);
    import swm_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMP_W  = (FILL_W > WSIZE_W) ? FILL_W : WSIZE_W;

    logic [WSIZE_W-1:0]         window_size_reg;
    logic [WSIZE_W-1:0]         window_size_next;
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          fill_next;
    logic                       pend_reg;
    logic                       pend_next;
    logic                       pend_mv_reg;
    logic                       pend_mv_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [MEDIAN_W-1:0] out_twice_reg;
    logic signed [MEDIAN_W-1:0] out_twice_next;
    logic                       out_mv_reg;
    logic                       out_mv_next;

    logic [CMP_W-1:0]           ws_ext;
    logic [FILL_W-1:0]          k_eff;
    logic [FILL_W-1:0]          fill_m1;
    logic [FILL_W-1:0]          fill_ins;
    logic [FILL_W-1:0]          lo_idx;
    logic [FILL_W-1:0]          hi_idx;
    logic                       full;
    logic                       over;
    logic                       hold_off;
    logic                       advance;
    logic                       accept;
    logic                       evict_only;
    logic                       out_load;
    swm_ctrl_t                  ctrl;
    logic [AGE_W-1:0]           last_age;
    logic signed [SAMPLE_W-1:0] tap_val [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] lo_val;
    logic signed [SAMPLE_W-1:0] hi_val;

    // Config register
    assign window_size_next = cfg_wr_en ? cfg_wr_data : window_size_reg;

    // Effective window length, clamped to 1..WINDOW_MAX
    assign ws_ext = CMP_W'(window_size_reg);
    always_comb
    begin
        if (ws_ext == '0)
        begin
            k_eff = FILL_W'(1);
        end
        else if (ws_ext > CMP_W'(WINDOW_MAX))
        begin
            k_eff = FILL_W'(WINDOW_MAX);
        end
        else
        begin
            k_eff = ws_ext[FILL_W-1:0];
        end
    end

    assign full     = (fill_reg >= k_eff);
    assign over     = (fill_reg > k_eff);
    assign fill_m1  = fill_reg - FILL_W'(1);
    assign last_age = fill_m1[AGE_W-1:0];

    // Handshake: chain may change only if the pending result can move on
    assign out_load   = pend_reg & (~out_valid_reg | median_ch.ready);
    assign advance    = ~pend_reg | out_load;
    assign hold_off   = over & ~sample_ch.new_sequence;
    assign sample_ch.ready = advance & ~hold_off;
    assign accept     = sample_ch.valid & sample_ch.ready;
    assign evict_only = sample_ch.valid & advance & hold_off;

    // Chain control
    assign ctrl.clear  = accept & sample_ch.new_sequence;
    assign ctrl.insert = accept;
    assign ctrl.evict  = (accept & ~sample_ch.new_sequence & full) | evict_only;

    // Fill count after this request
    always_comb
    begin
        if (sample_ch.new_sequence)
        begin
            fill_ins = FILL_W'(1);
        end
        else if (full)
        begin
            fill_ins = fill_reg;
        end
        else
        begin
            fill_ins = fill_reg + FILL_W'(1);
        end
    end

    always_comb
    begin
        if (accept)
        begin
            fill_next = fill_ins;
        end
        else if (evict_only)
        begin
            fill_next = fill_m1;
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    // Pending result flag
    assign pend_next    = accept | (pend_reg & ~out_load);
    assign pend_mv_next = accept ? (fill_ins == k_eff) : pend_mv_reg;

    swm_chain #(
        .WINDOW_MAX (WINDOW_MAX),
        .AGE_W      (AGE_W)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .new_val  (sample_ch.sample),
        .last_age (last_age),
        .tap_val  (tap_val)
    );

    // Middle-order taps: (k-1)/2 and k/2, from 0
    assign lo_idx = (k_eff - FILL_W'(1)) >> 1;
    assign hi_idx = k_eff >> 1;

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (FILL_W'(i) == lo_idx)
            begin
                lo_val = tap_val[i];
            end
            if (FILL_W'(i) == hi_idx)
            begin
                hi_val = tap_val[i];
            end
        end
    end

    // Output register
    always_comb
    begin
        out_twice_next = out_twice_reg;
        out_mv_next    = out_mv_reg;
        if (out_load)
        begin
            out_mv_next    = pend_mv_reg;
            out_twice_next = pend_mv_reg ? (MEDIAN_W'(lo_val) + MEDIAN_W'(hi_val)) : '0;
        end
    end

    assign out_valid_next = out_load | (out_valid_reg & ~median_ch.ready);

    assign median_ch.valid        = out_valid_reg;
    assign median_ch.median_twice = out_twice_reg;
    assign median_ch.median_valid = out_mv_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WSIZE_W'(1);
            fill_reg        <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            window_size_reg <= window_size_next;
            fill_reg        <= fill_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pend_mv_reg   <= pend_mv_next;
        out_twice_reg <= out_twice_next;
        out_mv_reg    <= out_mv_next;
    end

endmodule

`default_nettype wire

>>> rtl/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the median block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_median_defines.svh"

module swm_checker #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_wr_en,
    input logic [swm_pkg::WSIZE_W-1:0]         cfg_wr_data,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [swm_pkg::MEDIAN_W-1:0] median_twice,
    input logic                                median_valid
);
    import swm_pkg::*;

    logic [WSIZE_W-1:0] ws_reg;
    logic               odd_win;

    // Local copy of window_size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WSIZE_W'(1);
        end
        else if (cfg_wr_en)
        begin
            ws_reg <= cfg_wr_data;
        end
    end

    // Odd window: both middle taps are the same slot
    assign odd_win = ws_reg[0] && (int'(ws_reg) <= WINDOW_MAX);

    `SWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `SWM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(median_twice) && $stable(median_valid), "result changed while stalled")
    `SWM_ASSERT(a_zero_filling, out_valid && !median_valid, median_twice == '0, "nonzero median while window filling")
    `SWM_ASSERT(a_odd_even, out_valid && median_valid && odd_win, median_twice[0] == 1'b0, "odd window gave odd twice-median")
    `SWM_ASSERT(a_unit_full, out_valid && (ws_reg == WSIZE_W'(1)), median_valid, "unit window not reported full")

endmodule

bind sliding_window_median swm_checker #(
    .WINDOW_MAX (WINDOW_MAX)
) u_swm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (median_ch.valid),
    .out_ready    (median_ch.ready),
    .median_twice (median_ch.median_twice),
    .median_valid (median_ch.median_valid)
);

`default_nettype wire
